// ===== sv/band_meter_fall_and_peak_hold_defines.svh =====
// Assertion macros shared by the band meter RTL.
`ifndef BAND_METER_FALL_AND_PEAK_HOLD_DEFINES_SVH
`define BAND_METER_FALL_AND_PEAK_HOLD_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define BMFP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define BMFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bmfp_pkg.sv =====
// Shared types, constants and helpers of the band meter.
package bmfp_pkg;

  localparam int NUM_BANDS = 64;
  localparam int BAND_W    = 6;
  localparam int LEVEL_W   = 16;
  localparam int HOLD_W    = 7;
  localparam int ADDR_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [LEVEL_W-1:0] FALL_STEP_RST   = 16'd3277;
  localparam logic [HOLD_W-1:0]  PEAK_HOLD_RST   = 7'd70;
  localparam logic               SLOW_FALLS_RST  = 1'b1;
  localparam logic               PEAKS_EN_RST    = 1'b0;

  typedef enum logic [1:0] {
    REG_FALL_STEP  = 2'd0,
    REG_PEAK_HOLD  = 2'd1,
    REG_SLOW_FALLS = 2'd2,
    REG_PEAKS_EN   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] shown;
    logic [LEVEL_W-1:0] peak;
    logic [HOLD_W-1:0]  hold;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Subtract with floor at zero.
  function automatic logic [LEVEL_W-1:0] sat_sub(input logic [LEVEL_W-1:0] a,
                                                 input logic [LEVEL_W-1:0] b);
    logic [LEVEL_W:0] diff;
    diff = {1'b0, a} - {1'b0, b};
    return diff[LEVEL_W] ? '0 : diff[LEVEL_W-1:0];
  endfunction

endpackage

// ===== sv/bmfp_ram.sv =====
// Generic simple dual-port RAM with registered read, old data on collision.
module bmfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/band_meter_fall_and_peak_hold.sv =====
// Pipe: stage 1 holds the accepted request, stage 2 updates the shown level, stage 3 loads out_* (3-stage pipe).
// Throughput: one request per cycle unless stalled, every band, back to back on the same band too;
//   a per-band RAM read at accept plus forwarding from stages 2 and 3 sets this.
// Stall: the whole pipe freezes only while a result waits and out_ready is low.
// Reset (rst_n, synchronous): registers to defaults, all bands unseen, pipe empty.
// No clearing pass: unseen bands read hold 0 and ignore the RAM.
`include "band_meter_fall_and_peak_hold_defines.svh"

module band_meter_fall_and_peak_hold (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bmfp_pkg::BAND_W-1:0]     in_band_index,
  input  logic [bmfp_pkg::LEVEL_W-1:0]    in_band_level,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bmfp_pkg::BAND_W-1:0]     out_band,
  output logic [bmfp_pkg::LEVEL_W-1:0]    out_shown_level,
  output logic [bmfp_pkg::LEVEL_W-1:0]    out_peak_level,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bmfp_pkg::PADDR_W-1:0]    paddr,
  input  logic [bmfp_pkg::PDATA_W-1:0]    pwdata,
  output logic [bmfp_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import bmfp_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0] fall_step_r;
  logic [HOLD_W-1:0]  peak_hold_r;
  logic               slow_falls_r;
  logic               peaks_en_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_step_r  <= FALL_STEP_RST;
      peak_hold_r  <= PEAK_HOLD_RST;
      slow_falls_r <= SLOW_FALLS_RST;
      peaks_en_r   <= PEAKS_EN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FALL_STEP:  fall_step_r  <= pwdata[LEVEL_W-1:0];
        REG_PEAK_HOLD:  peak_hold_r  <= pwdata[HOLD_W-1:0];
        REG_SLOW_FALLS: slow_falls_r <= pwdata[0];
        REG_PEAKS_EN:   peaks_en_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_FALL_STEP:  prdata[LEVEL_W-1:0] = fall_step_r;
      REG_PEAK_HOLD:  prdata[HOLD_W-1:0]  = peak_hold_r;
      REG_SLOW_FALLS: prdata[0]           = slow_falls_r;
      REG_PEAKS_EN:   prdata[0]           = peaks_en_r;
      default:        prdata              = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipe control: every stage advances together unless the result is stuck.
  // ---------------------------------------------------------------------------
  logic advance;
  logic out_valid_r;

  assign advance  = !(out_valid_r && !out_ready);
  assign in_ready = advance;

  // ---------------------------------------------------------------------------
  // Band state: shown/peak/hold in RAM, seen bits in flops.
  // The RAM is read at accept; writes land as an item leaves stage 2.
  // ---------------------------------------------------------------------------
  logic               seen_r [NUM_BANDS];
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_entry;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             rd_entry;

  bmfp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BANDS)
  ) u_state_ram (
    .clk     (clk),
    .we      (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (advance),
    .rd_addr (ADDR_W'(in_band_index)),
    .rd_data (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        seen_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      seen_r[wr_addr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: accepted request, RAM read in flight.
  // ---------------------------------------------------------------------------
  logic               s1_valid_r;
  logic [BAND_W-1:0]  s1_band_r;
  logic [LEVEL_W-1:0] s1_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_band_r  <= in_band_index;
      s1_level_r <= in_band_level;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2 logic: merge newer writes, update the shown level.
  // ---------------------------------------------------------------------------
  logic               s2_valid_r;
  logic [BAND_W-1:0]  s2_band_r;
  logic               s2_inr_r;
  logic               s2_first_r;
  logic [LEVEL_W-1:0] s2_shown_r;
  logic [LEVEL_W-1:0] s2_peak_r;
  logic [HOLD_W-1:0]  s2_hold_r;

  logic               s3_inr_r;
  logic               s3_pen_r;
  logic [HOLD_W-1:0]  s3_hold_r;
  logic [BAND_W-1:0]  out_band_r;
  logic [LEVEL_W-1:0] out_shown_r;
  logic [LEVEL_W-1:0] out_peak_r;

  logic               s1_inr;
  logic [ADDR_W-1:0]  s1_addr;
  logic               hit2;
  logic               hit3;
  logic               s1_seen;
  logic [LEVEL_W-1:0] old_shown;
  logic [LEVEL_W-1:0] fell;
  logic [LEVEL_W-1:0] shown_nxt;
  logic [LEVEL_W-1:0] peak_fwd;
  logic [HOLD_W-1:0]  hold_fwd;

  assign s1_inr  = (9'(s1_band_r) < 9'(NUM_BANDS));
  assign s1_addr = ADDR_W'(s1_band_r);
  // Stage 2 holds the newest pending item, stage 3 the one the RAM read missed.
  assign hit2    = s2_valid_r && s2_inr_r && (s2_band_r == s1_band_r);
  assign hit3    = out_valid_r && s3_inr_r && (out_band_r == s1_band_r);
  assign s1_seen = hit2 || hit3 || (s1_inr && seen_r[s1_addr]);

  always_comb begin
    if (hit2) begin
      old_shown = s2_shown_r;
    end else if (hit3) begin
      old_shown = out_shown_r;
    end else begin
      old_shown = rd_entry.shown;
    end
    // Peak and hold of stage 2 are not final yet; stage 3 patches them in.
    if (!s1_seen) begin
      peak_fwd = s1_level_r;
      hold_fwd = '0;
    end else if (hit3) begin
      peak_fwd = out_peak_r;
      hold_fwd = s3_hold_r;
    end else begin
      peak_fwd = rd_entry.peak;
      hold_fwd = rd_entry.hold;
    end
    fell = sat_sub(old_shown, fall_step_r);
    if (s1_inr && s1_seen && slow_falls_r && (s1_level_r < old_shown)) begin
      shown_nxt = (fell < s1_level_r) ? s1_level_r : fell;
    end else begin
      shown_nxt = s1_level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_band_r  <= s1_band_r;
      s2_inr_r   <= s1_inr;
      s2_first_r <= !s1_seen;
      s2_shown_r <= shown_nxt;
      s2_peak_r  <= peak_fwd;
      s2_hold_r  <= hold_fwd;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3 logic: peak hold and fall, write back, load the result register.
  // ---------------------------------------------------------------------------
  logic               hitc;
  logic [LEVEL_W-1:0] peak_in;
  logic [HOLD_W-1:0]  hold_in;
  logic [LEVEL_W-1:0] peak_fell;
  logic [LEVEL_W-1:0] peak_nxt;
  logic [HOLD_W-1:0]  hold_nxt;

  // The item ahead may be the same band; take its final peak and hold.
  assign hitc      = out_valid_r && s3_inr_r && (out_band_r == s2_band_r);
  assign peak_in   = hitc ? out_peak_r : s2_peak_r;
  assign hold_in   = hitc ? s3_hold_r : s2_hold_r;
  assign peak_fell = sat_sub(peak_in, fall_step_r);

  always_comb begin
    peak_nxt = peak_in;
    hold_nxt = hold_in;
    if (!s2_inr_r) begin
      peak_nxt = s2_shown_r;
    end else if (s2_first_r) begin
      peak_nxt = s2_shown_r;
      if (peaks_en_r) begin
        hold_nxt = peak_hold_r;
      end
    end else if (peaks_en_r) begin
      if (s2_shown_r >= peak_in) begin
        peak_nxt = s2_shown_r;
        hold_nxt = peak_hold_r;
      end else if (hold_in != '0) begin
        hold_nxt = hold_in - 1'b1;
      end else begin
        peak_nxt = (peak_fell < s2_shown_r) ? s2_shown_r : peak_fell;
      end
    end
  end

  assign wr_en          = advance && s2_valid_r && s2_inr_r;
  assign wr_addr        = ADDR_W'(s2_band_r);
  assign wr_entry.shown = s2_shown_r;
  assign wr_entry.peak  = peak_nxt;
  assign wr_entry.hold  = hold_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_band_r  <= s2_band_r;
      out_shown_r <= s2_shown_r;
      out_peak_r  <= peak_nxt;
      s3_hold_r   <= hold_nxt;
      s3_inr_r    <= s2_inr_r;
      s3_pen_r    <= peaks_en_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_band        = out_band_r;
  assign out_shown_level = out_shown_r;
  assign out_peak_level  = out_peak_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `BMFP_ASSERT_SAME(a_peak_not_below_shown, out_valid_r && s3_pen_r, out_peak_r >= out_shown_r, "peak below shown level with peaks on")
  `BMFP_ASSERT_NEXT(a_stage2_reaches_out, advance && s2_valid_r, out_valid_r, "stage 2 request lost on its way out")
  `BMFP_ASSERT_NEXT(a_written_band_seen, wr_en, seen_r[$past(wr_addr)], "written band not marked seen")

endmodule

// ===== sim/band_meter_monitor.sv =====
// Band meter checker: watches the request, result and register ports, predicts and compares.
module band_meter_monitor (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [bmfp_pkg::BAND_W-1:0]  in_band_index,
  input  logic [bmfp_pkg::LEVEL_W-1:0] in_band_level,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [bmfp_pkg::BAND_W-1:0]  out_band,
  input  logic [bmfp_pkg::LEVEL_W-1:0] out_shown_level,
  input  logic [bmfp_pkg::LEVEL_W-1:0] out_peak_level,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bmfp_pkg::PADDR_W-1:0] paddr,
  input  logic [bmfp_pkg::PDATA_W-1:0] pwdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           pending,
  output int                           compared
);
  import bmfp_pkg::*;

  typedef struct packed {
    logic [BAND_W-1:0]  band;
    logic [LEVEL_W-1:0] shown;
    logic [LEVEL_W-1:0] peak;
  } meter_reading_t;

  meter_reading_t     expected_readings[$];

  logic [LEVEL_W-1:0] fall_step;
  logic [HOLD_W-1:0]  hold_frames;
  logic               slow_on;
  logic               peaks_on;

  logic               seen_q  [NUM_BANDS];
  logic [LEVEL_W-1:0] shown_q [NUM_BANDS];
  logic [LEVEL_W-1:0] peak_q  [NUM_BANDS];
  logic [HOLD_W-1:0]  hold_q  [NUM_BANDS];

  function automatic logic [LEVEL_W-1:0] drop_by_step(input logic [LEVEL_W-1:0] v);
    return (v > fall_step) ? v - fall_step : '0;
  endfunction

  // Advance one band's ballistics by one frame and return what the display shows.
  function automatic meter_reading_t meter_ballistics(input logic [BAND_W-1:0]  band,
                                                      input logic [LEVEL_W-1:0] level);
    meter_reading_t     r;
    logic [LEVEL_W-1:0] shown;
    logic [LEVEL_W-1:0] peak;
    logic [HOLD_W-1:0]  hold;
    r.band = band;
    if (int'(band) >= NUM_BANDS) begin
      r.shown = level;
      r.peak  = level;
      return r;
    end
    hold = hold_q[band];
    if (!seen_q[band]) begin
      seen_q[band] = 1'b1;
      shown = level;
      peak  = level;
      if (peaks_on) hold = hold_frames;
    end else begin
      shown = shown_q[band];
      peak  = peak_q[band];
      if (slow_on && level < shown) begin
        shown = drop_by_step(shown);
        if (shown < level) shown = level;
      end else begin
        shown = level;
      end
      if (peaks_on) begin
        if (shown >= peak) begin
          peak = shown;
          hold = hold_frames;
        end else if (hold != '0) begin
          hold = hold - 1'b1;
        end else begin
          peak = drop_by_step(peak);
          if (peak < shown) peak = shown;
        end
      end
    end
    shown_q[band] = shown;
    peak_q[band]  = peak;
    hold_q[band]  = hold;
    r.shown = shown;
    r.peak  = peak;
    return r;
  endfunction

  always @(posedge clk) begin
    meter_reading_t got;
    meter_reading_t want;
    meter_reading_t fresh;
    reg_idx_t       idx;
    if (!rst_n) begin
      fall_step   = FALL_STEP_RST;
      hold_frames = PEAK_HOLD_RST;
      slow_on     = SLOW_FALLS_RST;
      peaks_on    = PEAKS_EN_RST;
      for (int b = 0; b < NUM_BANDS; b++) begin
        seen_q[b] = 1'b0;
        hold_q[b] = '0;
      end
      expected_readings.delete();
      fail_count = 0;
      compared   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = reg_idx_t'(paddr[3:2]);
        case (idx)
          REG_FALL_STEP:  fall_step   = pwdata[LEVEL_W-1:0];
          REG_PEAK_HOLD:  hold_frames = pwdata[HOLD_W-1:0];
          REG_SLOW_FALLS: slow_on     = pwdata[0];
          REG_PEAKS_EN:   peaks_on    = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{out_band, out_shown_level, out_peak_level};
        if (expected_readings.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: band %0d shown %h peak %h",
                     got.band, got.shown, got.peak);
        end else begin
          want = expected_readings.pop_front();
          compared++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch band: expected %0d/%h/%h, got %0d/%h/%h (band/shown/peak)",
                       want.band, want.shown, want.peak, got.band, got.shown, got.peak);
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh = meter_ballistics(in_band_index, in_band_level);
        expected_readings.insert(expected_readings.size(), fresh);
      end
    end
    pending = expected_readings.size();
  end

endmodule

// ===== sim/band_meter_fall_and_peak_hold_test.sv =====
// Top-level testbench of the band meter: clock, reset, stimulus and verdict.
module band_meter_fall_and_peak_hold_test;
  import bmfp_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [BAND_W-1:0]    in_band_index;
  logic [LEVEL_W-1:0]   in_band_level;
  logic                 out_valid;
  logic                 out_ready;
  logic [BAND_W-1:0]    out_band;
  logic [LEVEL_W-1:0]   out_shown_level;
  logic [LEVEL_W-1:0]   out_peak_level;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  int                   fail_count;
  int                   pending;
  int                   compared;
  int                   requests_sent;
  int                   settings_used;

  // Stimulus-side memory of the last level per band, used to build falling runs.
  logic [LEVEL_W-1:0]   last_level [NUM_BANDS];
  logic [BAND_W-1:0]    band_pool  [4];

  // Rush flags switch off idling for a while on each side.
  bit                   feed_rush;
  bit                   drain_rush;

  band_meter_fall_and_peak_hold DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_band_index   (in_band_index),
    .in_band_level   (in_band_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_band        (out_band),
    .out_shown_level (out_shown_level),
    .out_peak_level  (out_peak_level),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  band_meter_monitor u_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_band_index   (in_band_index),
    .in_band_level   (in_band_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_band        (out_band),
    .out_shown_level (out_shown_level),
    .out_peak_level  (out_peak_level),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .pending         (pending),
    .compared        (compared)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: draw a stall per result, then hold ready until a result is taken.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      if ($urandom_range(0, 19) == 0) drain_rush = !drain_rush;
      stall = drain_rush ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Present one request after a random gap; return at the falling edge after acceptance.
  // With no gap, valid stays high straight into the next request.
  task automatic send_level(input logic [BAND_W-1:0] band, input logic [LEVEL_W-1:0] level);
    int gap;
    if ($urandom_range(0, 19) == 0) feed_rush = !feed_rush;
    gap = feed_rush ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_band_index <= band;
    in_band_level <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    last_level[band] = level;
    requests_sent++;
  endtask

  // Two-phase register write: setup, then access; pready is always high.
  // Return at the falling edge after the access with the port still selected.
  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, drain outstanding results, then load a full register set.
  task automatic apply_settings(input logic [LEVEL_W-1:0] step, input logic [HOLD_W-1:0] hold,
                                input logic slow, input logic peaks);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    write_reg(REG_FALL_STEP,  {{(PDATA_W-LEVEL_W){1'b0}}, step});
    write_reg(REG_PEAK_HOLD,  {{(PDATA_W-HOLD_W){1'b0}}, hold});
    write_reg(REG_SLOW_FALLS, {{(PDATA_W-1){1'b0}}, slow});
    write_reg(REG_PEAKS_EN,   {{(PDATA_W-1){1'b0}}, peaks});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  // Mostly falling runs on a few bands so holds expire and peaks decay; the rest is noise.
  task automatic random_traffic(input int count);
    int                 pool_n;
    int                 pick;
    logic [BAND_W-1:0]  band;
    logic [LEVEL_W-1:0] level;
    int                 drop;
    pool_n = $urandom_range(1, 4);
    for (int k = 0; k < 4; k++) band_pool[k] = BAND_W'($urandom_range(0, NUM_BANDS - 1));
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        band = band_pool[$urandom_range(0, pool_n - 1)];
        drop = $urandom_range(0, 3000);
        case ($urandom_range(0, 19))
          0:       level = '0;
          1:       level = '1;
          2, 3, 4: level = LEVEL_W'($urandom_range(0, 65535));
          default: level = (last_level[band] > drop) ? LEVEL_W'(last_level[band] - drop) : '0;
        endcase
      end else begin
        band  = BAND_W'($urandom_range(0, NUM_BANDS - 1));
        level = LEVEL_W'($urandom_range(0, 65535));
      end
      send_level(band, level);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_band_index = '0;
    in_band_level = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    requests_sent = 0;
    settings_used = 1;
    feed_rush     = 1'b0;
    drain_rush    = 1'b0;
    for (int b = 0; b < NUM_BANDS; b++) last_level[b] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings, peaks off: first load, slow fall, instant rise, equal level,
    // fall clamped at the new level; peaks report the stale stored value.
    send_level(6'd0,  16'hFFFF);
    send_level(6'd63, 16'h0000);
    send_level(6'd0,  16'h0000);
    send_level(6'd0,  16'hFFFF);
    send_level(6'd63, 16'h0000);
    send_level(6'd0,  16'hF000);
    send_level(6'd0,  16'hF300);

    // Largest step, no hold: shown and peak saturate at zero and clamp to the new level.
    apply_settings(16'hFFFF, 7'd0, 1'b1, 1'b1);
    send_level(6'd1, 16'h8000);
    send_level(6'd1, 16'h0001);
    send_level(6'd0, 16'h0000);
    send_level(6'd0, 16'h4000);

    // Zero step, longest hold: a falling level never moves, rises refresh the peak.
    apply_settings(16'h0000, 7'd127, 1'b1, 1'b1);
    send_level(6'd2, 16'h1234);
    send_level(6'd2, 16'h0000);
    send_level(6'd2, 16'hFFFF);
    send_level(6'd2, 16'h0100);

    // Direct follow with a one-frame hold: count down, then decay the peak by one.
    apply_settings(16'h0001, 7'd1, 1'b0, 1'b1);
    send_level(6'd3, 16'hAAAA);
    send_level(6'd3, 16'h5555);
    send_level(6'd3, 16'h5555);
    send_level(6'd3, 16'hFFFF);
    send_level(6'd3, 16'h0000);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       apply_settings(16'd3277, 7'd70,  1'b1, 1'b1);
        1:       apply_settings(16'hFFFF, 7'd0,   1'b1, 1'b1);
        2:       apply_settings(16'd1,    7'd3,   1'b1, 1'b1);
        3:       apply_settings(16'd0,    7'd100, 1'b0, 1'b1);
        4:       apply_settings(LEVEL_W'($urandom_range(0, 65535)), 7'd5, 1'b1, 1'b0);
        default: apply_settings(LEVEL_W'($urandom_range(0, 65535)),
                                HOLD_W'($urandom_range(0, 127)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      random_traffic(72);
    end

    // Wait out the last results, then let the pipe settle with some margin.
    in_valid <= 1'b0;
    for (int i = 0; i < 2000 && pending != 0; i++) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("band meter run: %0d requests over %0d register settings, %0d results compared",
             requests_sent, settings_used, compared);
    $display("random stalls on both channels, bursts on repeated bands, %0d left open",
             pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== band_meter_fall_and_peak_hold.f =====
+incdir+sv
sv/bmfp_pkg.sv
sv/bmfp_ram.sv
sv/band_meter_fall_and_peak_hold.sv
sim/band_meter_monitor.sv
sim/band_meter_fall_and_peak_hold_test.sv
